>>> hdl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants for the segment renumbering and stats block.
// ----------------------------------------------------------------------------
package sgr_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int MAX_DIM      = 4096;
    localparam int ID_W         = $clog2(MAX_SEGMENTS);
    localparam int NID_W        = ID_W + 1;
    localparam int POS_W        = $clog2(MAX_DIM);
    localparam int DIM_W        = 13;
    localparam int CNT_W        = 25;

    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef struct packed {
        logic [1:0]        command;
        logic signed [31:0] raw_label;
        logic [7:0]        query_id;
    } t_in;

    typedef struct packed {
        logic signed [8:0] new_label;
        logic              frame_done;
        logic [8:0]        frame_segments;
        logic              frame_empty;
        logic              table_full;
        logic [24:0]       pixel_total;
        logic [11:0]       box_left;
        logic [11:0]       box_top;
        logic [12:0]       box_width;
        logic [12:0]       box_height;
    } t_out;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] min_x;
        logic [POS_W-1:0] max_x;
        logic [POS_W-1:0] min_y;
        logic [POS_W-1:0] max_y;
    } t_stat;

    // Update strobe broadcast along the row of cells
    typedef struct packed {
        logic             we;
        logic             alloc;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_cell_ctl;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

>>> hdl/sgr_cell.sv
// ----------------------------------------------------------------------------
// sgr_cell
// One id slot: raw label tag, match compare and pixel count / bounding box.
// ----------------------------------------------------------------------------
module sgr_cell (
    input  logic                 i_clk,
    input  logic [sgr_pkg::ID_W-1:0]  i_idx,
    input  logic [31:0]          i_raw,
    input  logic [sgr_pkg::NID_W-1:0] i_base,
    input  logic [sgr_pkg::NID_W-1:0] i_next,
    input  sgr_pkg::t_cell_ctl   i_ctl,
    output logic                 o_match,
    output sgr_pkg::t_stat       o_stat
);
    import sgr_pkg::*;

    logic [31:0] r_tag;
    t_stat       r_stat;
    logic        hit_we;

    assign o_match = ({1'b0, i_idx} >= i_base) && ({1'b0, i_idx} < i_next) &&
                     (r_tag == i_raw);
    assign o_stat  = r_stat;
    assign hit_we  = i_ctl.we && (i_ctl.id == i_idx);

    always_ff @(posedge i_clk) begin
        if (hit_we) begin
            if (i_ctl.alloc) begin
                r_tag         <= i_raw;
                r_stat.count  <= CNT_W'(1);
                r_stat.min_x  <= i_ctl.x;
                r_stat.max_x  <= i_ctl.x;
                r_stat.min_y  <= i_ctl.y;
                r_stat.max_y  <= i_ctl.y;
            end else begin
                if (r_stat.count != '1) r_stat.count <= r_stat.count + CNT_W'(1);
                if (i_ctl.x < r_stat.min_x) r_stat.min_x <= i_ctl.x;
                if (i_ctl.x > r_stat.max_x) r_stat.max_x <= i_ctl.x;
                if (i_ctl.y < r_stat.min_y) r_stat.min_y <= i_ctl.y;
                if (i_ctl.y > r_stat.max_y) r_stat.max_y <= i_ctl.y;
            end
        end
    end

endmodule

>>> hdl/segment_renumber_and_region_stats.sv
// ----------------------------------------------------------------------------
// segment_renumber_and_region_stats
// Renumbers raster labels to global ids and keeps per-id count and box.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one transaction per pixel,
// query or clear. Output channel: o_out_valid / i_out_stall return exactly
// one result per input transaction, in order.
// Each transaction goes through accept, tag lookup across the row of
// cells (all slots compare in parallel, match registered), then update of
// the matched or newly allocated slot and load of the output register.
// No new transaction is accepted until the current one leaves its update
// step, as this lookup-then-update sequence uses the shared cell row.
// A finished result sits in the output register; the next transaction is
// accepted and looked up meanwhile, and holds in its update step only while
// the receiver stalls a still-pending result.
// Reset (synchronous, active low) empties all id tables logically (next id
// and frame base to zero), zeroes the raster position and the sticky full
// flag, and loads width 640 and height 480. No clearing pass is needed.
// Configuration writes go through i_cfg_we / i_cfg_addr / i_cfg_data and
// take effect on the next pixel.
// ----------------------------------------------------------------------------
module segment_renumber_and_region_stats (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [12:0]   i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sgr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sgr_pkg::t_out o_out_data
);
    import sgr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]       r_state;
    t_in              r_item;
    logic [DIM_W-1:0] r_width, r_height;
    logic [NID_W-1:0] r_next_id, r_base;
    logic [POS_W-1:0] r_col, r_row;
    logic             r_full;
    logic             r_hit;
    logic [ID_W-1:0]  r_hit_idx;
    t_stat            r_qstat;
    logic             r_qvalid;
    logic             r_out_valid;
    t_out             r_out;

    logic [MAX_SEGMENTS-1:0] match;
    t_stat                   stat [MAX_SEGMENTS];
    t_cell_ctl               ctl;
    logic                    any_hit;
    logic [ID_W-1:0]         hit_idx;
    logic                    upd_go, is_pix;
    logic [DIM_W-1:0]        w_eff, h_eff;
    logic [NID_W-1:0]        n_next_id;
    logic                    n_full;
    t_out                    n_out;

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
            sgr_cell u_cell (
                .i_clk   (i_clk),
                .i_idx   (ID_W'(g)),
                .i_raw   (r_item.raw_label),
                .i_base  (r_base),
                .i_next  (r_next_id),
                .i_ctl   (ctl),
                .o_match (match[g]),
                .o_stat  (stat[g])
            );
        end
    endgenerate

    // Tags in the live range are unique, so OR the indexes of matching slots
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            if (match[i]) hit_idx = hit_idx | ID_W'(i);
        end
    end
    assign any_hit = |match;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign upd_go      = (r_state == ST_UPD) && !(r_out_valid && i_out_stall);
    assign is_pix      = (r_item.command == CMD_PIXEL) && !r_item.raw_label[31];
    assign w_eff       = eff_dim(r_width);
    assign h_eff       = eff_dim(r_height);

    always_comb begin
        ctl       = '0;
        ctl.x     = r_col;
        ctl.y     = r_row;
        n_next_id = r_next_id;
        n_full    = r_full;
        n_out     = '0;
        n_out.new_label = 9'sh1FF;
        if (r_item.command == CMD_PIXEL) begin
            if (is_pix) begin
                if (r_hit) begin
                    ctl.we = upd_go;
                    ctl.id = r_hit_idx;
                    n_out.new_label = $signed({1'b0, r_hit_idx});
                end else if (r_next_id == NID_W'(MAX_SEGMENTS)) begin
                    n_full = 1'b1;
                end else begin
                    ctl.we    = upd_go;
                    ctl.alloc = 1'b1;
                    ctl.id    = r_next_id[ID_W-1:0];
                    n_next_id = r_next_id + NID_W'(1);
                    n_out.new_label = $signed({1'b0, r_next_id[ID_W-1:0]});
                end
            end
            if ({1'b0, r_col} + DIM_W'(1) >= w_eff &&
                {1'b0, r_row} + DIM_W'(1) >= h_eff) begin
                n_out.frame_done     = 1'b1;
                n_out.frame_segments = 9'(n_next_id - r_base);
                n_out.frame_empty    = (n_next_id == r_base);
            end
        end else if (r_item.command == CMD_QUERY && r_qvalid) begin
            n_out.pixel_total = r_qstat.count;
            n_out.box_left    = r_qstat.min_x;
            n_out.box_top     = r_qstat.min_y;
            n_out.box_width   = 13'({1'b0, r_qstat.max_x} - {1'b0, r_qstat.min_x} + 13'd1);
            n_out.box_height  = 13'({1'b0, r_qstat.max_y} - {1'b0, r_qstat.min_y} + 13'd1);
        end
        if (r_item.command == CMD_CLEAR) n_full = 1'b0;
        n_out.table_full = n_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= DIM_W'(640);
            r_height    <= DIM_W'(480);
            r_next_id   <= '0;
            r_base      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_addr == REG_WIDTH)  r_width  <= i_cfg_data;
            if (i_cfg_we && i_cfg_addr == REG_HEIGHT) r_height <= i_cfg_data;
            // Hold a stalled result, load a fresh one on update
            r_out_valid <= upd_go || (r_out_valid && i_out_stall);
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) r_state <= ST_LOOK;
                end
                ST_LOOK: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (upd_go) begin
                        r_state     <= ST_IDLE;
                        r_full      <= n_full;
                        if (r_item.command == CMD_PIXEL) begin
                            r_next_id <= n_next_id;
                            if ({1'b0, r_col} + DIM_W'(1) >= w_eff) begin
                                r_col <= '0;
                                if ({1'b0, r_row} + DIM_W'(1) >= h_eff) begin
                                    r_row  <= '0;
                                    r_base <= n_next_id;
                                end else begin
                                    r_row <= r_row + POS_W'(1);
                                end
                            end else begin
                                r_col <= r_col + POS_W'(1);
                            end
                        end else if (r_item.command == CMD_CLEAR) begin
                            r_next_id <= '0;
                            r_base    <= '0;
                            r_col     <= '0;
                            r_row     <= '0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) r_item <= i_in_data;
        if (r_state == ST_LOOK) begin
            r_hit     <= any_hit;
            r_hit_idx <= hit_idx;
            r_qstat   <= stat[r_item.query_id[ID_W-1:0]];
            r_qvalid  <= ({1'b0, r_item.query_id[ID_W-1:0]} < r_next_id);
        end
        if (upd_go) r_out <= n_out;
    end

    a_base_le_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= r_next_id)
        else $error("frame base ran past next id");
    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id <= NID_W'(MAX_SEGMENTS))
        else $error("next id beyond table size");
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match))
        else $error("raw label matched more than one live slot");
    a_upd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> r_out_valid && r_state == ST_IDLE)
        else $error("update did not load the output register");

endmodule

>>> dv/segment_renumber_and_region_stats_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_renumber_and_region_stats_tb
// Self-checking bench: raster label streams, queries and clears are driven
// through the valid/stall input channel. Every accepted transaction is run
// through a local renumber/statistics predictor, and every returned result is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module segment_renumber_and_region_stats_tb;
    import sgr_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int         NSEG        = 256;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [12:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;

    segment_renumber_and_region_stats u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Predictor state
    logic [31:0] tag_mem [NSEG];
    logic [24:0] pix_cnt [NSEG];
    logic [11:0] lo_x [NSEG];
    logic [11:0] hi_x [NSEG];
    logic [11:0] lo_y [NSEG];
    logic [11:0] hi_y [NSEG];
    int unsigned alloc_next;
    int unsigned base_id;
    int unsigned cur_col;
    int unsigned cur_row;
    logic        full_flag;
    logic [12:0] width_reg;
    logic [12:0] height_reg;

    t_in  pend_q[$];
    t_out label_result_q[$];

    int   tx_pct;
    int   rx_pct;
    int   hold_cnt;
    bit   hold_send;
    bit   in_taken;
    int   n_fail;
    int   n_checked;
    int   n_frames;
    int   n_full;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic int unsigned clamp_dim(input logic [12:0] v);
        if (v == 13'd0) return 1;
        if (v > 13'd4096) return 4096;
        return {19'd0, v};
    endfunction

    function automatic void queue_item(input t_in t);
        pend_q.insert(pend_q.size(), t);
    endfunction

    function automatic void wipe_tables();
        for (int i = 0; i < NSEG; i++) begin
            tag_mem[i] = '0;
            pix_cnt[i] = '0;
            lo_x[i] = '0;
            hi_x[i] = '0;
            lo_y[i] = '0;
            hi_y[i] = '0;
        end
        alloc_next = 0;
        base_id = 0;
        cur_col = 0;
        cur_row = 0;
        full_flag = 1'b0;
    endfunction

    function automatic t_out predict_stats(input t_in it);
        t_out        r;
        int unsigned x;
        int unsigned y;
        int unsigned w;
        int unsigned h;
        int unsigned id;
        bit          hit;
        r = '0;
        r.new_label = -9'sd1;
        case (it.command)
            CMD_PIXEL: begin
                x = cur_col;
                y = cur_row;
                w = clamp_dim(width_reg);
                h = clamp_dim(height_reg);
                if (!it.raw_label[31]) begin
                    id = alloc_next;
                    hit = 1'b0;
                    for (int i = base_id; i < alloc_next && i < NSEG; i++) begin
                        if (!hit && tag_mem[i] == it.raw_label) begin
                            id = i;
                            hit = 1'b1;
                        end
                    end
                    if (!hit) begin
                        if (alloc_next >= NSEG) begin
                            full_flag = 1'b1;
                            id = NSEG;
                        end else begin
                            tag_mem[id] = it.raw_label;
                            pix_cnt[id] = '0;
                            lo_x[id] = 12'(x);
                            hi_x[id] = 12'(x);
                            lo_y[id] = 12'(y);
                            hi_y[id] = 12'(y);
                            alloc_next = id + 1;
                        end
                    end
                    if (id < NSEG) begin
                        if (pix_cnt[id] != '1) pix_cnt[id] = pix_cnt[id] + 25'd1;
                        if (x < lo_x[id]) lo_x[id] = 12'(x);
                        if (x > hi_x[id]) hi_x[id] = 12'(x);
                        if (y < lo_y[id]) lo_y[id] = 12'(y);
                        if (y > hi_y[id]) hi_y[id] = 12'(y);
                        r.new_label = 9'(id);
                    end
                end
                if (x + 1 >= w) begin
                    cur_col = 0;
                    if (y + 1 >= h) begin
                        cur_row = 0;
                        r.frame_done = 1'b1;
                        r.frame_segments = 9'(alloc_next - base_id);
                        r.frame_empty = (alloc_next == base_id);
                        base_id = alloc_next;
                    end else begin
                        cur_row = y + 1;
                    end
                end else begin
                    cur_col = x + 1;
                end
            end
            CMD_QUERY: begin
                if (it.query_id < alloc_next) begin
                    r.pixel_total = pix_cnt[it.query_id];
                    r.box_left = lo_x[it.query_id];
                    r.box_top = lo_y[it.query_id];
                    r.box_width = 13'(hi_x[it.query_id]) - 13'(lo_x[it.query_id]) + 13'd1;
                    r.box_height = 13'(hi_y[it.query_id]) - 13'(lo_y[it.query_id]) + 13'd1;
                end
            end
            CMD_CLEAR: wipe_tables();
            default: ;
        endcase
        r.table_full = full_flag;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            n_fail++;
        end
    endtask

    // Driver: hold the payload until the transaction is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pend_q.size() != 0 && !hold_send && $urandom_range(0, 99) >= tx_pct) begin
                i_in_data <= pend_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    // Receiver stall
    always @(negedge i_clk) begin
        if (hold_cnt > 0) hold_cnt = hold_cnt - 1;
        i_out_stall <= (hold_cnt > 0) || ($urandom_range(0, 99) < rx_pct);
    end

    // Accept side: predict on every accepted input transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            in_taken = 1'b1;
            label_result_q.insert(label_result_q.size(), predict_stats(i_in_data));
        end
    end

    // Monitor: compare every returned transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (label_result_q.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h", $time, o_out_data);
                n_fail++;
            end else begin
                e = label_result_q.pop_front();
                n_checked++;
                if (e.frame_done) n_frames++;
                if (e.table_full) n_full++;
                check_field("new_label", 32'(e.new_label), 32'(o_out_data.new_label));
                check_field("frame_done", 32'(e.frame_done), 32'(o_out_data.frame_done));
                check_field("frame_segments", 32'(e.frame_segments),
                            32'(o_out_data.frame_segments));
                check_field("frame_empty", 32'(e.frame_empty), 32'(o_out_data.frame_empty));
                check_field("table_full", 32'(e.table_full), 32'(o_out_data.table_full));
                check_field("pixel_total", 32'(e.pixel_total), 32'(o_out_data.pixel_total));
                check_field("box_left", 32'(e.box_left), 32'(o_out_data.box_left));
                check_field("box_top", 32'(e.box_top), 32'(o_out_data.box_top));
                check_field("box_width", 32'(e.box_width), 32'(o_out_data.box_width));
                check_field("box_height", 32'(e.box_height), 32'(o_out_data.box_height));
            end
        end
    end

    task automatic wait_drained();
        while (pend_q.size() != 0 || i_in_valid || label_result_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_dims(input logic [12:0] w, input logic [12:0] h);
        wait_drained();
        repeat (5) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_WIDTH;
        i_cfg_data <= w;
        width_reg = w;
        @(negedge i_clk);
        i_cfg_addr <= REG_HEIGHT;
        i_cfg_data <= h;
        height_reg = h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in mk(input logic [1:0] c, input logic [31:0] lab,
                               input logic [7:0] q);
        t_in t;
        t.command = c;
        t.raw_label = lab;
        t.query_id = q;
        return t;
    endfunction

    // Mostly labels drawn from a per-call pool, usually small so they repeat in a frame
    task automatic add_items(input int n, input int unsigned pool, input bit clears);
        logic [31:0] pbase;
        logic [31:0] lab;
        int          r;
        pbase = $urandom() & 32'h3FFF_FFFF;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) lab = $urandom() | 32'h8000_0000;
            else if (r < 12) lab = $urandom();
            else lab = (pbase + $urandom_range(0, pool - 1)) & 32'h7FFF_FFFF;
            r = $urandom_range(0, 99);
            if (r < 78 || (r >= 97 && !clears))
                queue_item(mk(CMD_PIXEL, lab, $urandom()));
            else if (r < 93)
                queue_item(mk(CMD_QUERY, $urandom(),
                    ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom()));
            else if (r < 97)
                queue_item(mk(CMD_UNKNOWN, $urandom(), $urandom()));
            else
                queue_item(mk(CMD_CLEAR, $urandom(), $urandom()));
        end
    endtask

    initial begin
        #5ms;
        $display("segment_renumber_and_region_stats: mismatch");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        tx_pct = 0;
        rx_pct = 0;
        hold_cnt = 0;
        hold_send = 1'b0;
        n_fail = 0;
        n_checked = 0;
        n_frames = 0;
        n_full = 0;
        width_reg = 13'd640;
        height_reg = 13'd480;
        wipe_tables();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a 4x2 frame with label extremes, an all-unlabeled frame,
        // queries in and out of range, an unknown command and a clear
        write_dims(13'd4, 13'd2);
        queue_item(mk(CMD_PIXEL, 32'h0000_0000, 8'h00));
        queue_item(mk(CMD_PIXEL, 32'h7FFF_FFFF, 8'hFF));
        queue_item(mk(CMD_PIXEL, 32'hFFFF_FFFF, 8'h00));
        queue_item(mk(CMD_PIXEL, 32'h8000_0000, 8'h00));
        queue_item(mk(CMD_PIXEL, 32'h0000_0000, 8'h00));
        queue_item(mk(CMD_PIXEL, 32'h5555_AAAA, 8'h00));
        queue_item(mk(CMD_PIXEL, 32'h7FFF_FFFF, 8'h00));
        queue_item(mk(CMD_PIXEL, 32'h0000_0000, 8'h00));
        for (int i = 0; i < 8; i++)
            queue_item(mk(CMD_PIXEL, 32'h8000_0000 | i, 8'h00));
        queue_item(mk(CMD_QUERY, 32'h0, 8'd0));
        queue_item(mk(CMD_QUERY, 32'h0, 8'd1));
        queue_item(mk(CMD_QUERY, 32'h0, 8'd2));
        queue_item(mk(CMD_QUERY, 32'h0, 8'd255));
        queue_item(mk(CMD_UNKNOWN, 32'hFFFF_FFFF, 8'hFF));
        queue_item(mk(CMD_CLEAR, 32'h0, 8'h00));
        queue_item(mk(CMD_QUERY, 32'h0, 8'd0));

        add_items(120, 6, 1'b1);
        tx_pct = 53;
        write_dims(13'd0, 13'd0);
        add_items(40, 3, 1'b1);
        write_dims(13'd1, 13'd5);
        add_items(100, 8, 1'b1);

        tx_pct = 0;
        rx_pct = 53;
        write_dims(13'd5, 13'd1);
        add_items(100, 5, 1'b1);
        // long receiver hold-off while the sender keeps offering
        hold_cnt = 150;
        add_items(50, 5, 1'b1);
        while (pend_q.size() > 25) @(posedge i_clk);
        // sender pause until the pipeline is empty
        hold_send = 1'b1;
        while (i_in_valid || label_result_q.size() != 0) @(posedge i_clk);
        hold_send = 1'b0;

        // Fill the id table past capacity
        tx_pct = 10;
        rx_pct = 10;
        write_dims(13'd16, 13'd8);
        queue_item(mk(CMD_CLEAR, 32'h0, 8'h00));
        add_items(360, 32'h4000_0000, 1'b0);
        add_items(20, 4, 1'b0);
        write_dims(13'd8191, 13'd0);
        add_items(20, 4, 1'b0);
        write_dims(13'd4096, 13'd4096);
        add_items(10, 4, 1'b1);

        tx_pct = 0;
        rx_pct = 0;
        write_dims(13'd7, 13'd3);
        add_items(150, 6, 1'b1);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d results, %0d frame ends, %0d with the table-full flag set.",
                 n_checked, n_frames, n_full);
        $display("Sizes ran from 1x1 to 4096x4096 under four idle and stall mixes.");
        if (n_fail == 0 && label_result_q.size() == 0) begin
            $display("segment_renumber_and_region_stats: match");
        end else begin
            $display("segment_renumber_and_region_stats: mismatch");
        end
        $finish;
    end

endmodule
